[hdl/blm_pkg.sv]
// Shared types and constants for the Brent line minimizer.
// Used by the multiplier, the divider, the sequencer core and the top level.
// No dependencies.
package blm_pkg;

   localparam int DATA_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int ITER_WIDTH     = 16;
   localparam int WIDE_WIDTH     = 64;
   localparam int PROD_WIDTH     = 2 * WIDE_WIDTH;
   localparam int MAG_BITS       = 62;
   localparam int DIV_BITS       = MAG_BITS + FRAC_BITS;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_BITS);
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic signed [WIDE_WIDTH-1:0] LIM62    = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [WIDE_WIDTH-1:0] GOLDEN   = 64'sd25033;
   // ceil(2^53 / 2000000): exact floor(width / 2000000) for any 32-bit width
   localparam logic [WIDE_WIDTH-1:0]        RECIP_M  = 64'd4503599628;
   localparam int                           RECIP_SH = 53;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_VALUE = 1'b1;

   localparam logic [2:0] ST_PROBE      = 3'd0;
   localparam logic [2:0] ST_CONVERGED  = 3'd1;
   localparam logic [2:0] ST_LIMIT      = 3'd2;
   localparam logic [2:0] ST_BAD_BOUNDS = 3'd3;
   localparam logic [2:0] ST_NO_SEARCH  = 3'd4;

   localparam logic [1:0] REG_LOWER     = 2'd0;
   localparam logic [1:0] REG_UPPER     = 2'd1;
   localparam logic [1:0] REG_TOLERANCE = 2'd2;
   localparam logic [1:0] REG_MAX_ITER  = 2'd3;

   typedef struct packed {
      logic                         cmd;
      logic signed [DATA_WIDTH-1:0] func_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] probe_point;
      logic signed [DATA_WIDTH-1:0] best_value;
      logic [ITER_WIDTH-1:0]        iteration_index;
      logic [2:0]                   status;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] lower_bound;
      logic signed [DATA_WIDTH-1:0] upper_bound;
      logic [DATA_WIDTH-2:0]        tolerance;
      logic [ITER_WIDTH-1:0]        max_iterations;
   } cfg_type;

   typedef struct packed {
      logic                         start;
      logic signed [WIDE_WIDTH-1:0] op_a;
      logic signed [WIDE_WIDTH-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [WIDE_WIDTH-1:0] result;
      logic [PROD_WIDTH-1:0]        product;
   } mul_rsp_type;

   typedef struct packed {
      logic                         start;
      logic signed [WIDE_WIDTH-1:0] numer;
      logic signed [WIDE_WIDTH-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [WIDE_WIDTH-1:0] quotient;
   } div_rsp_type;

endpackage

[hdl/blm_mul.sv]
// Iterative fixed-point multiplier: one 32x32 partial product per cycle.
// Depends on blm_pkg.
module blm_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  blm_pkg::mul_req_type mul_req,
   output blm_pkg::mul_rsp_type mul_rsp
);
   import blm_pkg::*;

   logic [WIDE_WIDTH-1:0] ua_ff, ua_in, ub_ff, ub_in;
   logic                  neg_ff, neg_in;
   logic [PROD_WIDTH-1:0] acc_ff, acc_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;

   logic [31:0]                 part_a, part_b;
   logic [WIDE_WIDTH-1:0]       partial;
   logic [PROD_WIDTH-1:0]       aligned;
   logic [WIDE_WIDTH-1:0]       mag;
   logic                        sat;

   always_comb begin
      part_a  = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      part_b  = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      partial = part_a * part_b;
      case (cnt_ff)
         2'd0:    aligned = {64'd0, partial};
         2'd3:    aligned = {partial, 64'd0};
         default: aligned = {32'd0, partial, 32'd0};
      endcase
   end

   always_comb begin
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         ua_in   = mul_req.op_a[63] ? -mul_req.op_a : mul_req.op_a;
         ub_in   = mul_req.op_b[63] ? -mul_req.op_b : mul_req.op_b;
         neg_in  = mul_req.op_a[63] ^ mul_req.op_b[63];
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + aligned;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
   end

   // Drop the fraction bits and saturate the magnitude to 2^62-1.
   always_comb begin
      sat             = |acc_ff[PROD_WIDTH-1:MAG_BITS+FRAC_BITS];
      mag             = sat ? LIM62 : {2'b00, acc_ff[MAG_BITS+FRAC_BITS-1:FRAC_BITS]};
      mul_rsp.done    = done_ff;
      mul_rsp.result  = neg_ff ? -mag : mag;
      mul_rsp.product = acc_ff;
   end

endmodule

[hdl/blm_div.sv]
// Restoring divider, one quotient bit per cycle, for the parabolic step.
// Depends on blm_pkg.
module blm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  blm_pkg::div_req_type div_req,
   output blm_pkg::div_rsp_type div_rsp
);
   import blm_pkg::*;

   logic [DIV_BITS-1:0]      work_ff, work_in;
   logic [WIDE_WIDTH-1:0]    rem_ff, rem_in, den_ff, den_in;
   logic                     neg_ff, neg_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, done_ff, done_in;

   logic [WIDE_WIDTH:0]   trial, diff;
   logic                  fits;
   logic [WIDE_WIDTH-1:0] nmag, mag;
   logic                  sat;

   always_comb begin
      trial = {rem_ff, work_ff[DIV_BITS-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
      nmag  = div_req.numer[63] ? -div_req.numer : div_req.numer;
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         work_in = {nmag[MAG_BITS-1:0], {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = div_req.denom;
         neg_in  = div_req.numer[63];
         cnt_in  = DIV_CNT_WIDTH'(DIV_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[WIDE_WIDTH-1:0] : trial[WIDE_WIDTH-1:0];
         work_in = {work_ff[DIV_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      sat              = |work_ff[DIV_BITS-1:MAG_BITS];
      mag              = sat ? LIM62 : {2'b00, work_ff[MAG_BITS-1:0]};
      div_rsp.done     = done_ff;
      div_rsp.quotient = neg_ff ? -mag : mag;
   end

endmodule

[hdl/blm_core.sv]
// Sequencer and search state of the Brent line minimizer.
// Depends on blm_pkg; drives the shared blm_mul unit and the blm_div unit.
module blm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  blm_pkg::cfg_type     cfg,
   input  logic                 in_accept,
   input  blm_pkg::req_type     in_item,
   output logic                 in_ready,
   output logic                 out_valid,
   output blm_pkg::rsp_type     out_item,
   input  logic                 out_take,
   output blm_pkg::mul_req_type mul_req,
   input  blm_pkg::mul_rsp_type mul_rsp,
   output blm_pkg::div_req_type div_req,
   input  blm_pkg::div_rsp_type div_rsp
);
   import blm_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_TOLM  = 16'h0002,
      S_GOLM  = 16'h0004,
      S_UPD   = 16'h0008,
      S_HEAD  = 16'h0010,
      S_PR1   = 16'h0020,
      S_PR2   = 16'h0040,
      S_PR3   = 16'h0080,
      S_PR4   = 16'h0100,
      S_PQR   = 16'h0200,
      S_PLO   = 16'h0400,
      S_PHI   = 16'h0800,
      S_DIV   = 16'h1000,
      S_GSTEP = 16'h2000,
      S_FIN   = 16'h4000,
      S_DONE  = 16'h8000
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_FIRST = 3'b010,
      PH_RUN   = 3'b100
   } phase_type;

   function automatic logic signed [63:0] sat62(input logic signed [63:0] v);
      if (v > LIM62) return LIM62;
      else if (v < -LIM62) return -LIM62;
      else return v;
   endfunction

   function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat_data(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648) return 32'sh8000_0000;
      else return v[31:0];
   endfunction

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      go_ff, go_in;
   logic      left_ff, left_in;

   logic signed [31:0] brlo_ff, brlo_in, brhi_ff, brhi_in;
   logic signed [31:0] xb_ff, xb_in, xs_ff, xs_in, xt_ff, xt_in;
   logic signed [31:0] fb_ff, fb_in, fs_ff, fs_in, ft_ff, ft_in;
   logic signed [31:0] fin_ff, fin_in, pend_ff, pend_in, tol_ff, tol_in;
   logic signed [63:0] step_ff, step_in, prev_ff, prev_in;
   logic signed [63:0] p_ff, p_in, q_ff, q_in, r_ff, r_in;
   logic signed [63:0] qr_ff, qr_in, lo_ff, lo_in, d_ff, d_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;
   logic [32:0]           width_ff, width_in;
   rsp_type               out_ff, out_in;

   logic signed [63:0] sa_w, sb_w, x_w, tol_w, xs_w, xt_w, fb_w, fs_w, ft_w;
   logic signed [63:0] twox, sum, mid_off, gold_w, mres, qt;
   logic signed [63:0] psat, qdbl, p4, q4, ud, d_div, u_fin;
   logic               left_w, conv_w, limit_w, parab_w, cond_w, near_w;
   logic signed [32:0] span;
   logic [31:0]        tol_q;
   logic [28:0]        tol_quarter;

   always_comb begin
      sa_w   = sx32(brlo_ff);
      sb_w   = sx32(brhi_ff);
      x_w    = sx32(xb_ff);
      tol_w  = sx32(tol_ff);
      xs_w   = sx32(xs_ff);
      xt_w   = sx32(xt_ff);
      fb_w   = sx32(fb_ff);
      fs_w   = sx32(fs_ff);
      ft_w   = sx32(ft_ff);
      mres   = mul_rsp.result;
      qt     = div_rsp.quotient;
      twox   = x_w + x_w;
      sum    = sa_w + sb_w;
      mid_off = twox - sum;
      left_w = twox < sum;
      conv_w = abs64(mid_off) <= ((tol_w + tol_w + tol_w + tol_w) - (sb_w - sa_w));
      limit_w = (cfg.max_iterations != '0) && (iter_ff >= cfg.max_iterations);
      parab_w = tol_w < abs64(prev_ff);
      gold_w  = left_w ? (sb_w - x_w) : (sa_w - x_w);
      // Parabola numerator and denominator once the last product is in.
      psat   = sat62(p_ff - mres);
      qdbl   = sat62(q_ff - r_ff);
      qdbl   = qdbl + qdbl;
      p4     = (qdbl > 0) ? -psat : psat;
      q4     = abs64(qdbl);
      cond_w = ((abs64(p_ff) + abs64(p_ff)) < qr_ff) && (lo_ff < p_ff) && (p_ff < mres);
      // A parabolic point too close to a bracket end becomes a tolerance step.
      ud     = x_w + qt;
      near_w = ((ud - sa_w) < (tol_w + tol_w)) || ((sb_w - ud) < (tol_w + tol_w));
      d_div  = near_w ? (left_ff ? tol_w : -tol_w) : qt;
      if (tol_w <= abs64(d_ff)) u_fin = x_w + d_ff;
      else if (d_ff > 0) u_fin = x_w + tol_w;
      else u_fin = x_w - tol_w;
      span        = {cfg.upper_bound[31], cfg.upper_bound}
                  - {cfg.lower_bound[31], cfg.lower_bound};
      tol_quarter = cfg.tolerance[30:2];
      tol_q       = mul_rsp.product[RECIP_SH+31:RECIP_SH];
   end

   // Operand selection for the shared multiplier and the divider.
   always_comb begin
      mul_req.start = go_ff && (state_ff != S_DIV);
      mul_req.op_a  = '0;
      mul_req.op_b  = '0;
      unique case (state_ff)
         S_TOLM: begin
            mul_req.op_a = {31'd0, width_ff};
            mul_req.op_b = RECIP_M;
         end
         S_GOLM: begin
            mul_req.op_a = GOLDEN;
            mul_req.op_b = {31'd0, width_ff};
         end
         S_PR1: begin
            mul_req.op_a = x_w - xs_w;
            mul_req.op_b = fb_w - ft_w;
         end
         S_PR2: begin
            mul_req.op_a = x_w - xt_w;
            mul_req.op_b = fb_w - fs_w;
         end
         S_PR3: begin
            mul_req.op_a = x_w - xt_w;
            mul_req.op_b = q_ff;
         end
         S_PR4: begin
            mul_req.op_a = x_w - xs_w;
            mul_req.op_b = r_ff;
         end
         S_PQR: begin
            mul_req.op_a = q_ff;
            mul_req.op_b = r_ff;
         end
         S_PLO: begin
            mul_req.op_a = q_ff;
            mul_req.op_b = sa_w - x_w;
         end
         S_PHI: begin
            mul_req.op_a = q_ff;
            mul_req.op_b = sb_w - x_w;
         end
         S_GSTEP: begin
            mul_req.op_a = GOLDEN;
            mul_req.op_b = prev_ff;
         end
         default: begin
            mul_req.op_a = '0;
            mul_req.op_b = '0;
         end
      endcase
      div_req.start = go_ff && (state_ff == S_DIV);
      div_req.numer = p_ff;
      div_req.denom = q_ff;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      go_in    = 1'b0;
      left_in  = left_ff;
      brlo_in  = brlo_ff;
      brhi_in  = brhi_ff;
      xb_in    = xb_ff;
      xs_in    = xs_ff;
      xt_in    = xt_ff;
      fb_in    = fb_ff;
      fs_in    = fs_ff;
      ft_in    = ft_ff;
      fin_in   = fin_ff;
      pend_in  = pend_ff;
      tol_in   = tol_ff;
      step_in  = step_ff;
      prev_in  = prev_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      qr_in    = qr_ff;
      lo_in    = lo_ff;
      d_in     = d_ff;
      iter_in  = iter_ff;
      width_in = width_ff;
      out_in   = out_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (in_accept) begin
               if (in_item.cmd == CMD_START) begin
                  brlo_in  = '0;
                  brhi_in  = '0;
                  xb_in    = '0;
                  xs_in    = '0;
                  xt_in    = '0;
                  fb_in    = '0;
                  fs_in    = '0;
                  ft_in    = '0;
                  step_in  = '0;
                  prev_in  = '0;
                  pend_in  = '0;
                  tol_in   = '0;
                  iter_in  = '0;
                  phase_in = PH_IDLE;
                  if (cfg.lower_bound >= cfg.upper_bound) begin
                     out_in.probe_point     = '0;
                     out_in.best_value      = '0;
                     out_in.iteration_index = '0;
                     out_in.status          = ST_BAD_BOUNDS;
                     state_in               = S_DONE;
                  end else begin
                     brlo_in  = cfg.lower_bound;
                     brhi_in  = cfg.upper_bound;
                     width_in = span;
                     go_in    = 1'b1;
                     if (cfg.tolerance != '0) begin
                        tol_in   = (tol_quarter == '0) ? 32'sd1 : {3'b000, tol_quarter};
                        state_in = S_GOLM;
                     end else begin
                        state_in = S_TOLM;
                     end
                  end
               end else begin
                  unique case (phase_ff)
                     PH_FIRST: begin
                        fb_in    = in_item.func_value;
                        fs_in    = in_item.func_value;
                        ft_in    = in_item.func_value;
                        iter_in  = '0;
                        state_in = S_HEAD;
                     end
                     PH_RUN: begin
                        fin_in   = in_item.func_value;
                        state_in = S_UPD;
                     end
                     default: begin
                        out_in.probe_point     = xb_ff;
                        out_in.best_value      = fb_ff;
                        out_in.iteration_index = iter_ff;
                        out_in.status          = ST_NO_SEARCH;
                        state_in               = S_DONE;
                     end
                  endcase
               end
            end
         end
         S_TOLM: begin
            if (mul_rsp.done) begin
               tol_in   = (tol_q == '0) ? 32'sd1 : tol_q;
               go_in    = 1'b1;
               state_in = S_GOLM;
            end
         end
         S_GOLM: begin
            if (mul_rsp.done) begin
               xb_in                  = brlo_ff + mres[31:0];
               xs_in                  = brlo_ff + mres[31:0];
               xt_in                  = brlo_ff + mres[31:0];
               pend_in                = brlo_ff + mres[31:0];
               phase_in               = PH_FIRST;
               out_in.probe_point     = brlo_ff + mres[31:0];
               out_in.best_value      = '0;
               out_in.iteration_index = '0;
               out_in.status          = ST_PROBE;
               state_in               = S_DONE;
            end
         end
         S_UPD: begin
            if (fin_ff <= fb_ff) begin
               if (pend_ff < xb_ff) brhi_in = xb_ff;
               else brlo_in = xb_ff;
               xt_in = xs_ff;
               ft_in = fs_ff;
               xs_in = xb_ff;
               fs_in = fb_ff;
               xb_in = pend_ff;
               fb_in = fin_ff;
            end else begin
               if (pend_ff < xb_ff) brlo_in = pend_ff;
               else brhi_in = pend_ff;
               if ((fin_ff <= fs_ff) || (xs_ff == xb_ff)) begin
                  xt_in = xs_ff;
                  ft_in = fs_ff;
                  xs_in = pend_ff;
                  fs_in = fin_ff;
               end else if ((fin_ff <= ft_ff) || (xt_ff == xb_ff) || (xt_ff == xs_ff)) begin
                  xt_in = pend_ff;
                  ft_in = fin_ff;
               end
            end
            if (iter_ff != '1) iter_in = iter_ff + 1'b1;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            left_in                = left_w;
            out_in.probe_point     = xb_ff;
            out_in.best_value      = fb_ff;
            out_in.iteration_index = iter_ff;
            if (limit_w) begin
               out_in.status = ST_LIMIT;
               phase_in      = PH_IDLE;
               state_in      = S_DONE;
            end else if (conv_w) begin
               out_in.status = ST_CONVERGED;
               phase_in      = PH_IDLE;
               state_in      = S_DONE;
            end else if (parab_w) begin
               go_in    = 1'b1;
               state_in = S_PR1;
            end else begin
               prev_in  = gold_w;
               go_in    = 1'b1;
               state_in = S_GSTEP;
            end
         end
         S_PR1: begin
            if (mul_rsp.done) begin
               r_in     = mres;
               go_in    = 1'b1;
               state_in = S_PR2;
            end
         end
         S_PR2: begin
            if (mul_rsp.done) begin
               q_in     = mres;
               go_in    = 1'b1;
               state_in = S_PR3;
            end
         end
         S_PR3: begin
            if (mul_rsp.done) begin
               p_in     = mres;
               go_in    = 1'b1;
               state_in = S_PR4;
            end
         end
         S_PR4: begin
            if (mul_rsp.done) begin
               p_in     = p4;
               q_in     = q4;
               r_in     = prev_ff;
               prev_in  = step_ff;
               go_in    = 1'b1;
               state_in = S_PQR;
            end
         end
         S_PQR: begin
            if (mul_rsp.done) begin
               qr_in    = abs64(mres);
               go_in    = 1'b1;
               state_in = S_PLO;
            end
         end
         S_PLO: begin
            if (mul_rsp.done) begin
               lo_in    = mres;
               go_in    = 1'b1;
               state_in = S_PHI;
            end
         end
         S_PHI: begin
            if (mul_rsp.done) begin
               go_in = 1'b1;
               if (cond_w) begin
                  state_in = S_DIV;
               end else begin
                  prev_in  = gold_w;
                  state_in = S_GSTEP;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               d_in     = d_div;
               state_in = S_FIN;
            end
         end
         S_GSTEP: begin
            if (mul_rsp.done) begin
               d_in     = mres;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            step_in                = d_ff;
            pend_in                = sat_data(u_fin);
            phase_in               = PH_RUN;
            out_in.probe_point     = sat_data(u_fin);
            out_in.best_value      = fb_ff;
            out_in.iteration_index = iter_ff;
            out_in.status          = ST_PROBE;
            state_in               = S_DONE;
         end
         S_DONE: begin
            if (out_take) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_IDLE;
         go_ff    <= 1'b0;
         brlo_ff  <= '0;
         brhi_ff  <= '0;
         xb_ff    <= '0;
         xs_ff    <= '0;
         xt_ff    <= '0;
         fb_ff    <= '0;
         fs_ff    <= '0;
         ft_ff    <= '0;
         pend_ff  <= '0;
         tol_ff   <= '0;
         step_ff  <= '0;
         prev_ff  <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         go_ff    <= go_in;
         brlo_ff  <= brlo_in;
         brhi_ff  <= brhi_in;
         xb_ff    <= xb_in;
         xs_ff    <= xs_in;
         xt_ff    <= xt_in;
         fb_ff    <= fb_in;
         fs_ff    <= fs_in;
         ft_ff    <= ft_in;
         pend_ff  <= pend_in;
         tol_ff   <= tol_in;
         step_ff  <= step_in;
         prev_ff  <= prev_in;
         iter_ff  <= iter_in;
      end
      left_ff  <= left_in;
      fin_ff   <= fin_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      qr_ff    <= qr_in;
      lo_ff    <= lo_in;
      d_ff     <= d_in;
      width_ff <= width_in;
      out_ff   <= out_in;
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);
   assign out_item  = out_ff;

endmodule

[hdl/brent_line_minimizer_unit.sv]
// Top level of the Brent line minimizer: register file, result register and units.
// Depends on blm_pkg, blm_mul, blm_div and blm_core.
//
// Usage. The block searches a minimum of an external function over
// [lower_bound, upper_bound] in signed Q16.16. Program the four registers over
// the csr_ port (byte addresses 0, 4, 8 and 12), then send a start beat
// (cmd 0) on the req_ channel. Every request beat yields exactly one rsp_ beat.
// A status of probe asks the caller to evaluate the function at probe_point
// and return the value in a req_ beat with cmd 1; converged or iteration limit
// ends the search with the best point. Bad bounds and values sent while no
// search is active are answered at once with their own status.
// Each product goes through the shared multiplier, and the parabolic division
// runs 78 one-bit steps. One beat is worked on at a time; req_stall stays high
// from acceptance until the result has moved into the output register, which
// can hold it while rsp_stall is high. Reset clears the registers to their
// defaults (upper bound 1.0) and leaves no search active.
module brent_line_minimizer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  blm_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output blm_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [blm_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [blm_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [blm_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import blm_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        core_ready, core_valid, core_take, accept, csr_write;
   rsp_type     core_item;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Register writes; the address picks one of the four words.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_LOWER:     cfg_in.lower_bound    = csr_pwdata;
            REG_UPPER:     cfg_in.upper_bound    = csr_pwdata;
            REG_TOLERANCE: cfg_in.tolerance      = csr_pwdata[DATA_WIDTH-2:0];
            REG_MAX_ITER:  cfg_in.max_iterations = csr_pwdata[ITER_WIDTH-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_LOWER:     csr_prdata = cfg_ff.lower_bound;
         REG_UPPER:     csr_prdata = cfg_ff.upper_bound;
         REG_TOLERANCE: csr_prdata = {1'b0, cfg_ff.tolerance};
         REG_MAX_ITER:  csr_prdata = {16'd0, cfg_ff.max_iterations};
         default:       csr_prdata = '0;
      endcase
   end

   // The output register frees the core as soon as a result is handed over.
   assign accept    = req_valid && !req_stall;
   assign req_stall = !core_ready;
   assign core_take = core_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (core_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_item;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_bound    <= '0;
         cfg_ff.upper_bound    <= 32'sd65536;
         cfg_ff.tolerance      <= '0;
         cfg_ff.max_iterations <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   blm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   blm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   blm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_accept (accept),
      .in_item   (req_data),
      .in_ready  (core_ready),
      .out_valid (core_valid),
      .out_item  (core_item),
      .out_take  (core_take),
      .mul_req   (mul_req),
      .mul_rsp   (mul_rsp),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

endmodule
